### rtl/core/ual_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ual_pkg
// Shared types and constants for the unique-key array list.
// ----------------------------------------------------------------------------
package ual_pkg;

    localparam int MaxEntries = 64;
    localparam int IdxW       = $clog2(MaxEntries);
    localparam int CntW       = IdxW + 1;
    localparam int KeyW       = 31;
    localparam int GradeW     = 16;
    localparam int SumW       = GradeW + IdxW + 1;

    typedef enum logic [3:0] {
        ACT_INS_FRONT = 4'd0,
        ACT_INS_BACK  = 4'd1,
        ACT_REM_FRONT = 4'd2,
        ACT_REM_BACK  = 4'd3,
        ACT_REM_KEY   = 4'd4,
        ACT_MODIFY    = 4'd5,
        ACT_READ      = 4'd6,
        ACT_SEARCH    = 4'd7,
        ACT_CLEAR     = 4'd8,
        ACT_STATS     = 4'd9
    } t_action;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_DUP      = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_BADPOS   = 3'd4;
    localparam logic [2:0] ST_EMPTY    = 3'd5;

    // Datapath operation codes
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,    // capture the transaction and clear accumulators
        OP_SCAN,     // accumulate stats from the entry read at index
        OP_MIN,      // min pass at index
        OP_SHR,      // move entry idx-1 to idx
        OP_SHL,      // move entry idx+1 to idx
        OP_WRITE,    // write latched key/grade at index
        OP_WRITE_NK, // write new key/grade at index
        OP_READ,     // read entry at index
        OP_DIV       // one restoring divide step
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [CntW-1:0]  idx;
        logic             rd;     // issue memory read at idx
    } t_cmd;

    typedef struct packed {
        logic              hit;      // registered read key equals compare key
        logic [KeyW-1:0]   rd_key;
        logic [GradeW-1:0] rd_grade;
    } t_sts;

endpackage

### rtl/core/ual_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ual_datapath
// Entry memories, latched transaction fields, stats accumulators and divider.
// ----------------------------------------------------------------------------
module ual_datapath (
    input  logic                         i_clk,
    input  ual_pkg::t_cmd                i_cmd,
    input  logic                         i_cmp_new,
    input  logic [ual_pkg::KeyW-1:0]     i_key,
    input  logic [ual_pkg::KeyW-1:0]     i_new_key,
    input  logic [ual_pkg::GradeW-1:0]   i_grade,
    input  logic [ual_pkg::CntW-1:0]     i_count,
    output ual_pkg::t_sts                o_sts,
    output logic [ual_pkg::GradeW-1:0]   o_max,
    output logic [ual_pkg::GradeW-1:0]   o_min,
    output logic [ual_pkg::GradeW-1:0]   o_mean
);

    logic [ual_pkg::KeyW-1:0]   r_kmem [ual_pkg::MaxEntries];
    logic [ual_pkg::GradeW-1:0] r_gmem [ual_pkg::MaxEntries];
    logic [ual_pkg::KeyW-1:0]   r_rkey, r_key, r_nkey;
    logic [ual_pkg::GradeW-1:0] r_rgrade, r_grade, r_max, r_min;
    logic [ual_pkg::SumW-1:0]   r_sum, r_rem;
    logic [ual_pkg::GradeW-1:0] r_quo;
    logic [ual_pkg::IdxW-1:0]   w_a;
    logic [ual_pkg::SumW:0]     w_trial;

    assign w_a = i_cmd.idx[ual_pkg::IdxW-1:0];
    assign w_trial = {r_rem, r_sum[ual_pkg::SumW-1]}
                     - {{(ual_pkg::SumW+1-ual_pkg::CntW){1'b0}}, i_count};

    // Read port and memory writes
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rkey   <= r_kmem[w_a];
            r_rgrade <= r_gmem[w_a];
        end
        case (i_cmd.op)
            ual_pkg::OP_SHR, ual_pkg::OP_SHL: begin
                r_kmem[w_a] <= r_rkey;
                r_gmem[w_a] <= r_rgrade;
            end
            ual_pkg::OP_WRITE: begin
                r_kmem[w_a] <= r_key;
                r_gmem[w_a] <= r_grade;
            end
            ual_pkg::OP_WRITE_NK: begin
                r_kmem[w_a] <= r_nkey;
                r_gmem[w_a] <= r_grade;
            end
            default: begin
            end
        endcase
    end

    // Transaction fields, accumulators, divider (sum shifts into remainder)
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            ual_pkg::OP_LATCH: begin
                r_key   <= i_key;
                r_nkey  <= i_new_key;
                r_grade <= i_grade;
                r_max   <= '0;
                r_sum   <= '0;
                r_rem   <= '0;
                r_quo   <= '0;
            end
            ual_pkg::OP_SCAN: begin
                if (r_rgrade > r_max) r_max <= r_rgrade;
                r_sum <= r_sum + {{(ual_pkg::SumW-ual_pkg::GradeW){1'b0}}, r_rgrade};
                r_min <= (r_rgrade > r_max) ? r_rgrade : r_max;
            end
            ual_pkg::OP_MIN: begin
                if (r_rgrade < r_min) r_min <= r_rgrade;
            end
            ual_pkg::OP_DIV: begin
                r_sum <= {r_sum[ual_pkg::SumW-2:0], 1'b0};
                if (!w_trial[ual_pkg::SumW]) begin
                    r_rem <= w_trial[ual_pkg::SumW-1:0];
                    r_quo <= {r_quo[ual_pkg::GradeW-2:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[ual_pkg::SumW-2:0], r_sum[ual_pkg::SumW-1]};
                    r_quo <= {r_quo[ual_pkg::GradeW-2:0], 1'b0};
                end
            end
            default: begin
            end
        endcase
    end

    assign o_sts.hit      = (r_rkey == (i_cmp_new ? r_nkey : r_key));
    assign o_sts.rd_key   = r_rkey;
    assign o_sts.rd_grade = r_rgrade;
    assign o_max  = r_max;
    assign o_min  = r_min;
    assign o_mean = r_quo;

endmodule

### rtl/core/ual_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ual_ctrl
// Sequencer for list actions: scans, shifts, stats passes and result hold.
// ----------------------------------------------------------------------------
module ual_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [3:0]                  i_action,
    input  logic [ual_pkg::KeyW-1:0]    i_key,
    input  logic [ual_pkg::IdxW-1:0]    i_position,
    input  logic                        i_cfg_we,
    input  logic [6:0]                  i_cfg_data,
    input  ual_pkg::t_sts               i_sts,
    output ual_pkg::t_cmd               o_cmd,
    output logic                        o_cmp_new,
    output logic [ual_pkg::CntW-1:0]    o_count,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output logic [2:0]                  o_status,
    output logic [ual_pkg::IdxW-1:0]    o_found,
    output logic                        o_rd_ok,
    output logic                        o_stats,
    output logic                        o_full
);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN_RD, S_SCAN, S_DECIDE, S_SHIFT_RD, S_SHIFT, S_PUT,
        S_STAT, S_MIN_RD, S_MIN, S_DIV, S_POS_RD, S_POS, S_DONE
    } t_state;

    t_state                    r_state;
    logic [3:0]                r_act;
    logic [ual_pkg::CntW-1:0]  r_count, r_idx, r_hit_idx, r_cap;
    logic [ual_pkg::IdxW-1:0]  r_pos;
    logic [4:0]                r_div;
    logic                      r_hit, r_pass2, r_key0;
    logic [2:0]                r_status;
    logic [ual_pkg::IdxW-1:0]  r_found;
    logic                      r_rd_ok, r_stats;
    logic [ual_pkg::CntW-1:0]  w_cap;
    logic [ual_pkg::CntW-1:0]  w_pos_ext;

    // Effective capacity clipped to 1..MaxEntries
    always_comb begin
        if (r_cap == '0) w_cap = ual_pkg::CntW'(1);
        else if (r_cap > ual_pkg::CntW'(ual_pkg::MaxEntries))
            w_cap = ual_pkg::CntW'(ual_pkg::MaxEntries);
        else w_cap = r_cap;
    end
    assign w_pos_ext = {1'b0, r_pos};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= ual_pkg::CntW'(ual_pkg::MaxEntries);
        end else if (i_cfg_we) begin
            r_cap <= ual_pkg::CntW'(i_cfg_data);
        end
    end

    // Command decode per state
    always_comb begin
        o_cmd.op  = ual_pkg::OP_NONE;
        o_cmd.idx = r_idx;
        o_cmd.rd  = 1'b0;
        case (r_state)
            S_IDLE:     if (i_valid) o_cmd.op = ual_pkg::OP_LATCH;
            S_SCAN_RD:  o_cmd.rd = 1'b1;
            S_SCAN:     if (r_act == ual_pkg::ACT_STATS) o_cmd.op = ual_pkg::OP_SCAN;
            S_SHIFT_RD: begin
                o_cmd.rd  = 1'b1;
                o_cmd.idx = (r_act == ual_pkg::ACT_INS_FRONT) ? r_idx - 1'b1
                                                               : r_idx + 1'b1;
            end
            S_SHIFT: o_cmd.op = (r_act == ual_pkg::ACT_INS_FRONT) ? ual_pkg::OP_SHR
                                                                   : ual_pkg::OP_SHL;
            S_PUT: o_cmd.op = (r_act == ual_pkg::ACT_MODIFY) ? ual_pkg::OP_WRITE_NK
                                                              : ual_pkg::OP_WRITE;
            S_MIN_RD: o_cmd.rd = 1'b1;
            S_MIN:    o_cmd.op = ual_pkg::OP_MIN;
            S_DIV:    o_cmd.op = ual_pkg::OP_DIV;
            S_POS_RD: begin
                o_cmd.rd  = 1'b1;
                o_cmd.idx = w_pos_ext;
            end
            default: begin
            end
        endcase
    end

    assign o_cmp_new = r_pass2;

    // Sequencer: state, count, and registered result flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_status <= ual_pkg::ST_OK;
            r_found  <= '0;
            r_rd_ok  <= 1'b0;
            r_stats  <= 1'b0;
            r_idx    <= '0;
            r_hit    <= 1'b0;
            r_pass2  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_act    <= i_action;
                        r_pos    <= i_position;
                        r_key0   <= (i_key == '0);
                        r_status <= ual_pkg::ST_OK;
                        r_found  <= '0;
                        r_rd_ok  <= 1'b0;
                        r_stats  <= 1'b0;
                        r_idx    <= '0;
                        r_hit    <= 1'b0;
                        r_pass2  <= 1'b0;
                        r_div    <= '0;
                        case (i_action)
                            ual_pkg::ACT_INS_FRONT, ual_pkg::ACT_INS_BACK: begin
                                if (r_count >= w_cap) begin
                                    r_status <= ual_pkg::ST_FULL;
                                    r_state  <= S_DONE;
                                end else r_state <= S_SCAN_RD;
                            end
                            ual_pkg::ACT_REM_FRONT, ual_pkg::ACT_REM_BACK,
                            ual_pkg::ACT_REM_KEY: begin
                                if (r_count == '0) begin
                                    r_status <= ual_pkg::ST_EMPTY;
                                    r_state  <= S_DONE;
                                end else if (i_action == ual_pkg::ACT_REM_BACK) begin
                                    r_count <= r_count - 1'b1;
                                    r_state <= S_DONE;
                                end else if (i_action == ual_pkg::ACT_REM_FRONT) begin
                                    r_hit     <= 1'b1;
                                    r_hit_idx <= '0;
                                    r_state   <= S_DECIDE;
                                end else r_state <= S_SCAN_RD;
                            end
                            ual_pkg::ACT_MODIFY, ual_pkg::ACT_READ: begin
                                if ({1'b0, i_position} >= r_count) begin
                                    r_status <= ual_pkg::ST_BADPOS;
                                    r_state  <= S_DONE;
                                end else r_state <= S_POS_RD;
                            end
                            ual_pkg::ACT_SEARCH: r_state <= S_SCAN_RD;
                            ual_pkg::ACT_CLEAR: begin
                                r_count <= '0;
                                r_state <= S_DONE;
                            end
                            ual_pkg::ACT_STATS: begin
                                r_stats <= 1'b1;
                                r_state <= S_SCAN_RD;
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_SCAN_RD: begin
                    if (r_idx >= r_count) r_state <= S_DECIDE;
                    else r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (r_act != ual_pkg::ACT_STATS && i_sts.hit) begin
                        r_hit     <= 1'b1;
                        r_hit_idx <= r_idx;
                        r_state   <= S_DECIDE;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_SCAN_RD;
                    end
                end
                S_DECIDE: begin
                    case (r_act)
                        ual_pkg::ACT_INS_FRONT, ual_pkg::ACT_INS_BACK: begin
                            if (r_hit) begin
                                r_status <= ual_pkg::ST_DUP;
                                r_state  <= S_DONE;
                            end else if (r_act == ual_pkg::ACT_INS_BACK) begin
                                r_idx   <= r_count;
                                r_state <= S_PUT;
                            end else begin
                                r_idx   <= r_count;
                                r_state <= (r_count == '0) ? S_PUT : S_SHIFT_RD;
                            end
                        end
                        ual_pkg::ACT_REM_FRONT, ual_pkg::ACT_REM_KEY: begin
                            if (!r_hit) begin
                                r_status <= ual_pkg::ST_NOTFOUND;
                                r_state  <= S_DONE;
                            end else if (r_hit_idx + 1'b1 >= r_count) begin
                                r_count <= r_count - 1'b1;
                                r_state <= S_DONE;
                            end else begin
                                r_idx   <= r_hit_idx;
                                r_state <= S_SHIFT_RD;
                            end
                        end
                        ual_pkg::ACT_MODIFY: begin
                            if (r_hit) begin
                                r_status <= ual_pkg::ST_DUP;
                                r_state  <= S_DONE;
                            end else begin
                                r_idx   <= w_pos_ext;
                                r_state <= S_PUT;
                            end
                        end
                        ual_pkg::ACT_SEARCH: begin
                            if (r_key0 || !r_hit) r_status <= ual_pkg::ST_NOTFOUND;
                            else r_found <= r_hit_idx[ual_pkg::IdxW-1:0];
                            r_state <= S_DONE;
                        end
                        ual_pkg::ACT_STATS: begin
                            r_idx   <= '0;
                            r_state <= S_MIN_RD;
                        end
                        default: r_state <= S_DONE;
                    endcase
                end
                S_SHIFT_RD: r_state <= S_SHIFT;
                S_SHIFT: begin
                    if (r_act == ual_pkg::ACT_INS_FRONT) begin
                        r_idx   <= r_idx - 1'b1;
                        r_state <= (r_idx == ual_pkg::CntW'(1)) ? S_PUT : S_SHIFT_RD;
                    end else if (r_idx + ual_pkg::CntW'(2) >= r_count) begin
                        r_count <= r_count - 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_SHIFT_RD;
                    end
                end
                S_PUT: begin
                    if (r_act != ual_pkg::ACT_MODIFY) r_count <= r_count + 1'b1;
                    r_state <= S_DONE;
                end
                S_MIN_RD: begin
                    if (r_idx >= r_count) begin
                        r_state <= (r_count == '0) ? S_DONE : S_DIV;
                    end else r_state <= S_MIN;
                end
                S_MIN: begin
                    r_idx   <= r_idx + 1'b1;
                    r_state <= S_MIN_RD;
                end
                S_DIV: begin
                    r_div <= r_div + 1'b1;
                    if (r_div == 5'(ual_pkg::SumW - 1)) r_state <= S_DONE;
                end
                S_POS_RD: r_state <= S_POS;
                S_POS: begin
                    if (r_act == ual_pkg::ACT_READ) begin
                        r_rd_ok <= 1'b1;
                        r_state <= S_DONE;
                    end else if (!i_sts.hit) begin
                        r_status <= ual_pkg::ST_NOTFOUND;
                        r_state  <= S_DONE;
                    end else begin
                        r_pass2 <= 1'b1;
                        r_idx   <= '0;
                        r_state <= S_SCAN_RD;
                    end
                end
                S_DONE: if (i_res_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_count     = r_count;
    assign o_status    = r_status;
    assign o_found     = r_found;
    assign o_rd_ok     = r_rd_ok;
    assign o_stats     = r_stats;
    assign o_full      = (r_count >= w_cap);

endmodule

### rtl/core/unique_key_array_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unique_key_array_list
// Bounded ordered list of unique-key records with search and statistics.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. Key scans read the entries held one
// by one, front inserts and compacting removes move one entry at a time, and
// stats take two passes over the entries plus a restoring divide; the single
// read port of the entry memory sets this pace. Reads of entries at or beyond
// the count are refused, so the memory needs no clear.
// ----------------------------------------------------------------------------
module unique_key_array_list (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [3:0]                  i_action,
    input  logic [ual_pkg::KeyW-1:0]    i_key,
    input  logic [ual_pkg::KeyW-1:0]    i_new_key,
    input  logic [ual_pkg::GradeW-1:0]  i_grade,
    input  logic [5:0]                  i_position,
    input  logic                        i_cfg_we,
    input  logic [6:0]                  i_cfg_data,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [2:0]                  o_status,
    output logic [5:0]                  o_found_index,
    output logic [30:0]                 o_key_out,
    output logic [15:0]                 o_grade_out,
    output logic [6:0]                  o_entry_count,
    output logic                        o_is_full,
    output logic                        o_is_empty,
    output logic [15:0]                 o_max_grade,
    output logic [15:0]                 o_min_grade,
    output logic [15:0]                 o_mean_grade
);

    ual_pkg::t_cmd               w_cmd;
    ual_pkg::t_sts               w_sts;
    logic                        w_cmp_new, w_rd_ok, w_stats;
    logic [ual_pkg::CntW-1:0]    w_count;
    logic [ual_pkg::GradeW-1:0]  w_max, w_min, w_mean;

    ual_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_action    (i_action),
        .i_key       (i_key),
        .i_position  (i_position),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_cmp_new   (w_cmp_new),
        .o_count     (w_count),
        .o_res_valid (o_valid),
        .i_res_ready (i_ready),
        .o_status    (o_status),
        .o_found     (o_found_index),
        .o_rd_ok     (w_rd_ok),
        .o_stats     (w_stats),
        .o_full      (o_is_full)
    );

    ual_datapath u_dp (
        .i_clk     (i_clk),
        .i_cmd     (w_cmd),
        .i_cmp_new (w_cmp_new),
        .i_key     (i_key),
        .i_new_key (i_new_key),
        .i_grade   (i_grade),
        .i_count   (w_count),
        .o_sts     (w_sts),
        .o_max     (w_max),
        .o_min     (w_min),
        .o_mean    (w_mean)
    );

    // Gate payload by action outcome
    assign o_key_out     = w_rd_ok ? w_sts.rd_key : '0;
    assign o_grade_out   = w_rd_ok ? w_sts.rd_grade : '0;
    assign o_entry_count = w_count;
    assign o_is_empty    = (w_count == '0);
    assign o_max_grade   = (w_stats && w_count != '0) ? w_max : '0;
    assign o_min_grade   = (w_stats && w_count != '0) ? w_min : '0;
    assign o_mean_grade  = (w_stats && w_count != '0) ? w_mean : '0;

    // No new transaction while a result is pending
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready)) else $error("ready during result");
    // Count never exceeds memory depth
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_entry_count <= 7'd64) else $error("count overflow");
    // Count and result valid hold while a result is stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_entry_count) && o_valid)
        else $error("result changed while stalled");

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the unique-key array list: a scoreboard predicts
// each response from its own copy of the list, and random idling, stalls and
// capacity changes drive the block through every action and status.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic [2:0]                 status;
    logic [5:0]                 found_index;
    logic [ual_pkg::KeyW-1:0]   key_out;
    logic [ual_pkg::GradeW-1:0] grade_out;
    logic [6:0]                 entry_count;
    logic                       is_full;
    logic                       is_empty;
    logic [15:0]                max_grade;
    logic [15:0]                min_grade;
    logic [15:0]                mean_grade;
} t_resp;

class list_scoreboard;
    logic [ual_pkg::KeyW-1:0]   keys[ual_pkg::MaxEntries];
    logic [ual_pkg::GradeW-1:0] grades[ual_pkg::MaxEntries];
    int                         count;
    int                         capacity;
    t_resp                      pending[$];
    int                         errors;

    function new();
        count    = 0;
        capacity = 64;
        errors   = 0;
    endfunction

    function int eff_cap();
        if (capacity == 0) return 1;
        if (capacity > ual_pkg::MaxEntries) return ual_pkg::MaxEntries;
        return capacity;
    endfunction

    function int locate(logic [ual_pkg::KeyW-1:0] k);
        for (int i = 0; i < count; i++) if (keys[i] == k) return i;
        return count;
    endfunction

    function void drop_at(int idx);
        for (int i = idx; i + 1 < count; i++) begin
            keys[i]   = keys[i+1];
            grades[i] = grades[i+1];
        end
        count--;
    endfunction

    // Apply one accepted transaction and queue its predicted response
    function void note_input(logic [3:0] act, logic [ual_pkg::KeyW-1:0] k,
                             logic [ual_pkg::KeyW-1:0] nk,
                             logic [ual_pkg::GradeW-1:0] g, logic [5:0] pos);
        t_resp r;
        int    idx;
        int    sum;
        r   = '0;
        sum = 0;
        case (act)
            ual_pkg::ACT_INS_FRONT, ual_pkg::ACT_INS_BACK: begin
                if (count >= eff_cap()) r.status = ual_pkg::ST_FULL;
                else if (locate(k) < count) r.status = ual_pkg::ST_DUP;
                else if (act == ual_pkg::ACT_INS_FRONT) begin
                    for (int i = count; i > 0; i--) begin
                        keys[i]   = keys[i-1];
                        grades[i] = grades[i-1];
                    end
                    keys[0] = k; grades[0] = g; count++;
                end else begin
                    keys[count] = k; grades[count] = g; count++;
                end
            end
            ual_pkg::ACT_REM_FRONT: begin
                if (count == 0) r.status = ual_pkg::ST_EMPTY; else drop_at(0);
            end
            ual_pkg::ACT_REM_BACK: begin
                if (count == 0) r.status = ual_pkg::ST_EMPTY; else count--;
            end
            ual_pkg::ACT_REM_KEY: begin
                if (count == 0) r.status = ual_pkg::ST_EMPTY;
                else begin
                    idx = locate(k);
                    if (idx < count) drop_at(idx); else r.status = ual_pkg::ST_NOTFOUND;
                end
            end
            ual_pkg::ACT_MODIFY: begin
                if (pos >= count) r.status = ual_pkg::ST_BADPOS;
                else if (keys[pos] != k) r.status = ual_pkg::ST_NOTFOUND;
                else if (locate(nk) < count) r.status = ual_pkg::ST_DUP;
                else begin
                    keys[pos] = nk; grades[pos] = g;
                end
            end
            ual_pkg::ACT_READ: begin
                if (pos >= count) r.status = ual_pkg::ST_BADPOS;
                else begin
                    r.key_out = keys[pos]; r.grade_out = grades[pos];
                end
            end
            ual_pkg::ACT_SEARCH: begin
                idx = locate(k);
                if (k == '0 || idx >= count) r.status = ual_pkg::ST_NOTFOUND;
                else r.found_index = 6'(idx);
            end
            ual_pkg::ACT_CLEAR: count = 0;
            ual_pkg::ACT_STATS: begin
                for (int i = 0; i < count; i++) begin
                    if (grades[i] > r.max_grade) r.max_grade = grades[i];
                    sum += grades[i];
                end
                r.min_grade = r.max_grade;
                for (int i = 0; i < count; i++)
                    if (grades[i] < r.min_grade) r.min_grade = grades[i];
                if (count != 0) r.mean_grade = 16'(sum / count);
            end
            default: ;
        endcase
        r.entry_count = 7'(count);
        r.is_full     = count >= eff_cap();
        r.is_empty    = count == 0;
        pending.push_back(r);
    endfunction

    // Compare one response against the oldest prediction
    function void check_result(t_resp got);
        t_resp exp;
        if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response %p", got);
            return;
        end
        exp = pending.pop_front();
        if (got !== exp) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p actual %p", exp, got);
        end
    endfunction
endclass

module tb_top;
    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic [3:0]                 action = '0;
    logic [ual_pkg::KeyW-1:0]   key = '0;
    logic [ual_pkg::KeyW-1:0]   new_key = '0;
    logic [ual_pkg::GradeW-1:0] grade = '0;
    logic [5:0]                 position = '0;
    logic                       cfg_we = 1'b0;
    logic [6:0]                 cfg_data = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    wire t_resp                 resp;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_off = 0;
    logic [ual_pkg::KeyW-1:0] key_pool[8];

    list_scoreboard sb = new();

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    unique_key_array_list dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_ready(in_ready),
        .i_action(action), .i_key(key), .i_new_key(new_key),
        .i_grade(grade), .i_position(position),
        .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .o_valid(out_valid), .i_ready(out_ready),
        .o_status(resp.status), .o_found_index(resp.found_index),
        .o_key_out(resp.key_out), .o_grade_out(resp.grade_out),
        .o_entry_count(resp.entry_count), .o_is_full(resp.is_full),
        .o_is_empty(resp.is_empty), .o_max_grade(resp.max_grade),
        .o_min_grade(resp.min_grade), .o_mean_grade(resp.mean_grade)
    );

    // Sample accepted responses at the rising edge
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) sb.check_result(resp);
    end

    // Receiver: random stalls, plus a long hold-off when requested
    always @(negedge clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offer one transaction and hold it until accepted
    task automatic send_item(logic [3:0] a, logic [ual_pkg::KeyW-1:0] k,
                             logic [ual_pkg::KeyW-1:0] nk,
                             logic [ual_pkg::GradeW-1:0] g, logic [5:0] p);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        action <= a; key <= k; new_key <= nk; grade <= g; position <= p;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        sb.note_input(a, k, nk, g, p);
        @(negedge clk);
    endtask

    // Drop valid, wait for all responses to drain, then let the block settle
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (300) @(negedge clk);
    endtask

    task automatic write_capacity(logic [6:0] c);
        drain();
        cfg_data <= c;
        cfg_we   <= 1'b1;
        @(negedge clk);
        cfg_we   <= 1'b0;
        sb.capacity = c;
    endtask

    function automatic logic [ual_pkg::KeyW-1:0] pick_key();
        if ($urandom_range(9) < 7) return key_pool[$urandom_range(7)];
        return ual_pkg::KeyW'($urandom);
    endfunction

    // Random transaction, mostly on a small key set so hits are common
    task automatic send_random();
        logic [3:0] a;
        logic [5:0] p;
        int r;
        r = $urandom_range(99);
        if (r < 30) a = 4'($urandom_range(1));
        else if (r < 97) a = 4'($urandom_range(9));
        else a = 4'($urandom_range(15, 10));
        p = (sb.count > 0 && $urandom_range(3) != 0) ? 6'($urandom_range(sb.count - 1))
                                                     : 6'($urandom_range(63));
        if (a == ual_pkg::ACT_MODIFY && p < sb.count && $urandom_range(1))
            send_item(a, sb.keys[p], pick_key(), ual_pkg::GradeW'($urandom), p);
        else
            send_item(a, pick_key(), pick_key(), ual_pkg::GradeW'($urandom), p);
    endtask

    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        for (int i = 0; i < 8; i++)
            key_pool[i] = (i == 0) ? '0 : ual_pkg::KeyW'($urandom);
        key_pool[1] = 31'h7fffffff;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty removes, extremes, every action
        send_item(ual_pkg::ACT_REM_FRONT, '0, '0, '0, '0);
        send_item(ual_pkg::ACT_REM_BACK, '0, '0, '0, '0);
        send_item(ual_pkg::ACT_REM_KEY, 31'd5, '0, '0, '0);
        send_item(ual_pkg::ACT_STATS, '0, '0, '0, '0);
        send_item(ual_pkg::ACT_SEARCH, '0, '0, '0, '0);
        send_item(ual_pkg::ACT_INS_BACK, 31'h7fffffff, '0, 16'hffff, '0);
        send_item(ual_pkg::ACT_INS_FRONT, '0, '0, '0, '0);
        send_item(ual_pkg::ACT_INS_BACK, 31'h7fffffff, '0, 16'd1, '0);
        send_item(ual_pkg::ACT_SEARCH, '0, '0, '0, '0);
        send_item(ual_pkg::ACT_SEARCH, 31'h7fffffff, '0, '0, '0);
        send_item(ual_pkg::ACT_READ, '0, '0, '0, 6'd1);
        send_item(ual_pkg::ACT_READ, '0, '0, '0, 6'd63);
        send_item(ual_pkg::ACT_MODIFY, '0, '0, 16'd5, '0);
        send_item(ual_pkg::ACT_MODIFY, 31'd1, 31'd2, 16'd5, '0);
        send_item(ual_pkg::ACT_MODIFY, '0, 31'h2aaaaaaa, 16'h5555, '0);
        send_item(ual_pkg::ACT_MODIFY, '0, '0, '0, 6'd5);
        send_item(ual_pkg::ACT_STATS, '0, '0, '0, '0);
        send_item(ual_pkg::ACT_REM_KEY, 31'd1234, '0, '0, '0);
        send_item(ual_pkg::ACT_REM_KEY, 31'h2aaaaaaa, '0, '0, '0);
        send_item(4'd15, '0, '0, '0, '0);
        send_item(ual_pkg::ACT_CLEAR, '0, '0, '0, '0);
        write_capacity(7'd0);
        send_item(ual_pkg::ACT_INS_BACK, 31'd9, '0, 16'd3, '0);
        send_item(ual_pkg::ACT_INS_FRONT, 31'd10, '0, 16'd3, '0);
        write_capacity(7'd127);

        // Random phases across capacities and idling patterns
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase
            case (ph)
                1: write_capacity(7'd1);
                2: write_capacity(7'd64);
                3: write_capacity(7'd5);
                5: write_capacity(7'd65);
                6: write_capacity(7'd2);
                7: write_capacity(7'd12);
                default: ;
            endcase
            if (ph == 4) hold_off = 400;
            for (int i = 0; i < 128; i++) send_random();
            // Full fill of the list in phase 2
            if (ph == 2) for (int i = 0; i < 66; i++)
                send_item(ual_pkg::ACT_INS_BACK, ual_pkg::KeyW'($urandom), '0,
                          ual_pkg::GradeW'($urandom), '0);
            if (ph == 2) send_item(ual_pkg::ACT_STATS, '0, '0, '0, '0);
        end

        drain();
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
